### rtl/sks_pkg.sv
// Shared constants and defaults for the streaming k-smallest selector.
`default_nettype none
package sks_pkg;

    localparam int K_MAX_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int K_TARGET_W     = 7;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam logic [K_TARGET_W-1:0] K_TARGET_RESET = K_TARGET_W'(1);

    // Word index of each register (paddr[2]).
    localparam logic REG_K_TARGET = 1'b0;

endpackage
`default_nettype wire

### rtl/sks_front.sv
// Front end: takes input beats and queues them for the selection back end.
`default_nettype none
module sks_front #(
    parameter int VALUE_WIDTH = sks_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_last,
    output logic                        o_q_valid,
    input  wire logic                   i_q_ready,
    output logic [VALUE_WIDTH-1:0]      o_q_value,
    output logic                        o_q_last
);
    import sks_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_WIDTH:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]        r_rd_ptr, n_rd_ptr;
    logic [FW-1:0]        r_fill,   n_fill;
    logic                 push, pop;

    assign o_ready   = (r_fill != FW'(QUEUE_DEPTH));
    assign o_q_valid = (r_fill != '0);
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_value = r_mem[r_rd_ptr][VALUE_WIDTH-1:0];
    assign o_q_last  = r_mem[r_rd_ptr][VALUE_WIDTH];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + FW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= {i_last, i_value};
        end
    end

endmodule
`default_nettype wire

### rtl/sks_back.sv
// Back end: sorted compare-and-shift cell chain, fill count and report register.
`default_nettype none
module sks_back #(
    parameter int K_MAX       = sks_pkg::K_MAX_DEF,
    parameter int VALUE_WIDTH = sks_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [sks_pkg::K_TARGET_W-1:0] i_k_target,
    input  wire logic                           i_q_valid,
    output logic                                o_q_ready,
    input  wire logic [VALUE_WIDTH-1:0]         i_q_value,
    input  wire logic                           i_q_last,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [VALUE_WIDTH-1:0]              o_out_value,
    output logic                                o_out_short
);
    import sks_pkg::*;

    localparam int CW = $clog2(K_MAX + 1);
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int EW = (CW > K_TARGET_W) ? CW : K_TARGET_W;

    logic signed [VALUE_WIDTH-1:0] r_cell [K_MAX];
    logic signed [VALUE_WIDTH-1:0] n_cell [K_MAX];
    logic signed [VALUE_WIDTH-1:0] key;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_rpt_pend, n_rpt_pend;
    logic [IW-1:0]        r_pick, n_pick;
    logic                 r_short, n_short;
    logic                 r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                 r_out_short;
    logic [EW-1:0]        k_ext, k_eff, n_ext;
    logic [CW-1:0]        m;
    logic [IW-1:0]        last_idx;
    logic [K_MAX-1:0]     ge, gt;
    logic                 grow, take, pop, load;

    assign key       = i_q_value;
    assign o_q_ready = !r_rpt_pend;
    assign pop       = i_q_valid && !r_rpt_pend;
    assign load      = r_rpt_pend && (!r_out_valid || i_out_ready);

    // Rank clamp: zero acts as one, anything above the store size as the store size.
    always_comb begin
        k_ext = EW'(i_k_target);
        if (k_ext == '0) begin
            k_eff = EW'(1);
        end else if (k_ext > EW'(K_MAX)) begin
            k_eff = EW'(K_MAX);
        end else begin
            k_eff = k_ext;
        end
    end

    assign n_ext    = EW'(r_count);
    assign grow     = (n_ext < k_eff);
    assign last_idx = IW'(r_count - CW'(1));
    assign take     = grow || ge[last_idx];
    // Cells taking part in the insertion: all held ones, or all but the largest.
    assign m        = grow ? r_count : r_count - CW'(1);

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        assign ge[g] = (r_cell[g] >= key);
        // Cells at or beyond the insertion end count as larger than the key.
        assign gt[g] = (CW'(g) >= m) || (r_cell[g] > key);
        if (g == 0) begin : g_head
            always_comb begin
                n_cell[g] = r_cell[g];
                if (pop && take && gt[g]) begin
                    n_cell[g] = key;
                end
            end
        end else begin : g_body
            always_comb begin
                n_cell[g] = r_cell[g];
                if (pop && take && (CW'(g) <= m) && gt[g]) begin
                    n_cell[g] = gt[g-1] ? r_cell[g-1] : key;
                end
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_rpt_pend = r_rpt_pend;
        n_pick     = r_pick;
        n_short    = r_short;
        if (load) begin
            n_rpt_pend = 1'b0;
        end
        if (pop) begin
            if (grow) begin
                n_count = r_count + CW'(1);
            end
            if (i_q_last) begin
                n_count    = '0;
                n_rpt_pend = 1'b1;
                n_pick     = grow ? IW'(r_count) : IW'(k_eff - EW'(1));
                n_short    = grow && ((n_ext + EW'(1)) < k_eff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rpt_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rpt_pend <= n_rpt_pend;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        r_pick <= n_pick;
        r_short <= n_short;
        if (load) begin
            r_out_value <= r_cell[r_pick];
            r_out_short <= r_short;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_short = r_out_short;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_count) <= EW'(K_MAX))
        else $error("held count beyond store size");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_q_last |=> (r_count == '0) && r_rpt_pend)
        else $error("last beat did not clear the store and raise a report");

    a_report_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rpt_pend))
        else $error("result shown without a pending report");

    a_hold_on_report : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rpt_pend |=> $stable(r_count) || !$past(r_rpt_pend))
        else $error("store changed while a report was pending");

endmodule
`default_nettype wire

### rtl/stream_k_smallest_select.sv
// A last beat's result passes through the queue and the report-pending register into the output
// register once that is free, and leaves it on a cycle with m_axis_tready high.
// Throughput: one beat per cycle, except while a report is pending after a last beat; the back end
// then holds its input until the report read of the cell chain after the final insertion is loaded.
// The four-entry queue keeps taking beats while the back end reports or the output stalls.
// Reset (synchronous, active low) empties the queue and store and sets k_target to 1.
`default_nettype none
module stream_k_smallest_select #(
    parameter int K_MAX       = sks_pkg::K_MAX_DEF,
    parameter int VALUE_WIDTH = sks_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tdata: value
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic                        s_axis_tlast,
    // tdata: kth_value
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: short_stream
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sks_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sks_pkg::PDATA_W-1:0] pwdata,
    output logic [sks_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import sks_pkg::*;

    localparam int TDW = ((VALUE_WIDTH + 7) / 8) * 8;

    logic [K_TARGET_W-1:0]  r_k_target;
    logic                   q_valid, q_ready, q_last;
    logic [VALUE_WIDTH-1:0] q_value;
    logic [VALUE_WIDTH-1:0] out_value;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_K_TARGET);
    assign prdata = (paddr[2] == REG_K_TARGET) ? PDATA_W'(r_k_target) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_target <= K_TARGET_RESET;
        end else if (cfg_wr) begin
            r_k_target <= pwdata[K_TARGET_W-1:0];
        end
    end

    sks_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_value   (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_last    (s_axis_tlast),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_value (q_value),
        .o_q_last  (q_last)
    );

    sks_back #(
        .K_MAX       (K_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_k_target  (r_k_target),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_value   (q_value),
        .i_q_last    (q_last),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (out_value),
        .o_out_short (m_axis_tuser)
    );

    assign m_axis_tdata = TDW'(out_value);

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking bench for stream_k_smallest_select: random beats, live k-smallest predictor.
`default_nettype none
module tb;
    import sks_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } t_stream_beat;

    typedef struct {
        logic signed [31:0] kth_value;
        logic               short_stream;
    } t_kth_report;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    // tdata: value
    logic [31:0]           s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic                  s_axis_tlast = 1'b0;
    // tdata: kth_value
    logic [31:0]           m_axis_tdata;
    // tuser: short_stream
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    t_stream_beat          pending_beats[$];
    t_kth_report           report_queue[$];

    // Predictor state: ascending store of the smallest values and the rank register.
    logic signed [31:0]    held_sorted[0:K_MAX_DEF-1];
    int                    held_n = 0;
    logic [K_TARGET_W-1:0] k_reg = K_TARGET_RESET;

    int                    fail_count = 0;
    int                    quiet_cycles = 0;
    int                    gap_left = 0;
    int                    burst_left = 1;
    int                    stall_left = 0;
    bit                    steady = 1'b0;

    stream_k_smallest_select dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int rank_in_use();
        if (k_reg == 0) return 1;
        if (k_reg > K_MAX_DEF) return K_MAX_DEF;
        return int'(k_reg);
    endfunction

    // Fold one accepted value into the store; on a last beat queue the report.
    task automatic absorb_value(input logic signed [31:0] v, input logic last);
        int k;
        int n;
        int pos;
        int pick;
        t_kth_report r;
        k = rank_in_use();
        n = held_n;
        pos = -1;
        if (n < k) begin
            pos = n;
            n = n + 1;
        end else if (v <= held_sorted[n-1]) begin
            pos = n - 1;  // displace the largest held value
        end
        if (pos >= 0) begin
            while (pos > 0 && held_sorted[pos-1] > v) begin
                held_sorted[pos] = held_sorted[pos-1];
                pos--;
            end
            held_sorted[pos] = v;
        end
        held_n = n;
        if (last) begin
            pick = (n < k) ? n : k;
            r.kth_value = held_sorted[pick-1];
            r.short_stream = (n < k);
            report_queue.insert(report_queue.size(), r);
            held_n = 0;
        end
    endtask

    task automatic add_beat(input logic signed [31:0] v, input logic last);
        t_stream_beat b;
        b.value = v;
        b.last = last;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic apb_write_k(input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_K_TARGET, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        k_reg = data[K_TARGET_W-1:0];
    endtask

    // Drain everything, then allow for beats that leave no report.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || report_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return 32'($urandom_range(0, 200)) - 32'd100;
        endcase
    endfunction

    task automatic queue_stream(input int len, input bit ends);
        for (int i = 0; i < len; i++)
            add_beat(random_value(), ends && (i == len - 1));
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_stream_beat b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0 && !steady) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                b = pending_beats.pop_front();
                s_axis_tdata <= b.value;
                s_axis_tlast <= b.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                    gap_left <= 0;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: mostly ready, with stalls of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n || steady) begin
            m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 8);
        end
    end

    always @(posedge i_clk) begin
        t_kth_report want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_value(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (report_queue.size() == 0) begin
                    $error("result beat with nothing expected: kth_value %0d",
                           $signed(m_axis_tdata));
                    fail_count++;
                end else begin
                    want = report_queue.pop_front();
                    if (m_axis_tdata !== want.kth_value) begin
                        $error("kth_value: expected %0d, got %0d",
                               want.kth_value, $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.short_stream) begin
                        $error("short_stream: expected %0b, got %0b",
                               want.short_stream, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int queued;
        int k_eff;
        int streams;
        int len;
        bit ends;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rank 1 straight out of reset: extremes of the value range.
        add_beat(32'sh8000_0000, 1'b1);
        add_beat(32'sh7fff_ffff, 1'b0);
        add_beat(32'sd0, 1'b0);
        add_beat(-32'sd1, 1'b0);
        add_beat(32'sh8000_0000, 1'b1);
        wait_idle();

        // Ties, then a stream shorter than k.
        apb_write_k(32'd3);
        add_beat(32'sd5, 1'b0);
        add_beat(32'sd5, 1'b0);
        add_beat(32'sd5, 1'b1);
        add_beat(32'sd7, 1'b0);
        add_beat(-32'sd3, 1'b1);
        wait_idle();

        // Rank zero behaves as one.
        apb_write_k(32'hffff_ff80);
        add_beat(32'sd10, 1'b0);
        add_beat(-32'sd10, 1'b0);
        add_beat(32'sd3, 1'b1);
        wait_idle();

        // Rank beyond the store depth clamps; stream is short.
        apb_write_k(32'd100);
        add_beat(32'sd1, 1'b0);
        add_beat(32'sd2, 1'b1);
        wait_idle();

        // Shrink the rank part way through a stream, then grow it again.
        apb_write_k(32'd4);
        for (int i = 9; i >= 5; i--)
            add_beat(i, 1'b0);
        wait_idle();
        apb_write_k(32'd2);
        add_beat(32'sd100, 1'b1);
        add_beat(32'sd1, 1'b0);
        add_beat(32'sd2, 1'b0);
        wait_idle();
        apb_write_k(32'd6);
        add_beat(32'sd3, 1'b1);
        wait_idle();

        queued = 0;
        while (queued < 530) begin
            case ($urandom_range(0, 9))
                0: apb_write_k({$urandom} & 32'hffff_ff80);
                1: apb_write_k(32'd1);
                2: apb_write_k(32'd64);
                3: apb_write_k($urandom_range(65, 127));
                4: apb_write_k($urandom_range(9, 63));
                default: apb_write_k($urandom_range(2, 8));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            k_eff = rank_in_use();
            streams = $urandom_range(1, 4);
            for (int s = 0; s < streams; s++) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, k_eff)
                                                  : $urandom_range(1, k_eff + 8);
                // Leave the final stream open now and then so the next rank lands mid-stream.
                ends = (s != streams - 1) || ($urandom_range(0, 3) != 0);
                queue_stream(len, ends);
                queued += len;
            end
            wait_idle();
        end
        steady = 1'b0;

        wait_idle();
        if (fail_count == 0 && report_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/sks_pkg.sv
rtl/sks_front.sv
rtl/sks_back.sv
rtl/stream_k_smallest_select.sv
test/tb.sv
